// ----- design/ts_pmt_stream_type_patcher_assert.svh -----
// assertion macros for the pmt stream type patcher
`ifndef TS_PMT_STREAM_TYPE_PATCHER_ASSERT_SVH
`define TS_PMT_STREAM_TYPE_PATCHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ts_pmt_pkg.sv -----
`timescale 1ns / 1ps
package ts_pmt_pkg;

  // position arithmetic width, wide enough for section length sums
  localparam int unsigned POS_W = 13;

  localparam logic [7:0]  TS_SYNC     = 8'h47;
  localparam logic [7:0]  PMT_TID     = 8'h02;
  localparam logic [7:0]  SYN_MASK    = 8'h7c;
  localparam logic [7:0]  SYN_VAL     = 8'h30;
  localparam logic [7:0]  PID_RSV     = 8'he0;
  localparam logic [7:0]  ES_RSV      = 8'h30;
  localparam logic [7:0]  PI_RSV      = 8'h0c;
  localparam logic [7:0]  SCR_MASK    = 8'hc0;
  localparam logic [31:0] CRC_POLY    = 32'h04c11db7;
  localparam logic [31:0] CRC_INIT    = 32'hffffffff;
  localparam logic [7:0]  MATCH_RST   = 8'h06;
  localparam logic [7:0]  REPLACE_RST = 8'h1b;

  // configuration register indexes
  localparam logic REG_MATCH   = 1'b0;
  localparam logic REG_REPLACE = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_ADAPT,
    PH_PTR,
    PH_SEC,
    PH_ENTRY,
    PH_TAIL,
    PH_FAIL
  } phase_e;

  // patch plan for the packet that just completed
  typedef struct packed {
    logic [7:0]  patch_off;
    logic [7:0]  patch_val;
    logic [7:0]  crc_off;
    logic [31:0] crc_val;
    logic        crc_en;
  } plan_t;

  // one byte of crc-32/mpeg-2, msb first
  function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- design/ts_pmt_if.sv -----
`timescale 1ns / 1ps
// input byte channel
interface ts_pmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// output byte channel
interface ts_pmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_first;
  logic       type_patched;
  logic       crc_rewritten;
  modport source (output valid, output out_byte, output out_valid, output out_first,
                  output type_patched, output crc_rewritten, input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_first,
                input type_patched, input crc_rewritten, output ready);
endinterface

// ----- design/ts_pmt_parser.sv -----
`timescale 1ns / 1ps
module ts_pmt_parser #(
  parameter int unsigned PACKET_LEN = 188,
  parameter int unsigned OFF_W      = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic                 last_i,
  input  logic [OFF_W-1:0]     off_i,
  input  logic [7:0]           byte_i,
  input  logic [7:0]           match_i,
  input  logic [7:0]           replace_i,
  output ts_pmt_pkg::plan_t    plan_o
);

  localparam int unsigned PW = ts_pmt_pkg::POS_W;
  localparam logic [PW-1:0] LenP = PW'(PACKET_LEN);

  ts_pmt_pkg::phase_e phase_q, phase_d;
  logic              ent_q, ent_d;
  logic [PW-1:0]     nf_q, nf_d, end_q, end_d;
  logic [OFF_W-1:0]  dpos_q, dpos_d, fpos_q, fpos_d, stop_q, stop_d;
  logic [3:0]        hi_q, hi_d;
  logic              first_q, first_d, fok_q, fok_d;
  logic [7:0]        ftype_q, ftype_d;
  logic [2:0]        ecnt_q, ecnt_d, capn_q, capn_d;
  logic [31:0]       crc_q, crc_d, snap_q, snap_d, cap_q, cap_d;
  logic [31:0]       col_q [8];
  logic [31:0]       col_d [8];
  logic [31:0]       csnap_q [8];
  logic [31:0]       csnap_d [8];

  logic [PW-1:0]     offp, sum;
  logic [OFF_W-1:0]  k;
  logic [31:0]       delta;
  logic [7:0]        dif;
  logic              patch_ok;

  assign offp = PW'(off_i);
  assign k    = off_i - dpos_q;

  // streaming parse of the section header and entry loop
  always_comb begin
    phase_d = phase_q;
    ent_d   = ent_q;
    nf_d    = nf_q;
    end_d   = end_q;
    dpos_d  = dpos_q;
    fpos_d  = fpos_q;
    stop_d  = stop_q;
    hi_d    = hi_q;
    first_d = first_q;
    fok_d   = fok_q;
    ftype_d = ftype_q;
    ecnt_d  = ecnt_q;
    capn_d  = capn_q;
    crc_d   = crc_q;
    snap_d  = snap_q;
    cap_d   = cap_q;
    col_d   = col_q;
    csnap_d = csnap_q;
    sum     = '0;
    if (acc_i) begin
      if (last_i) begin
        phase_d = ts_pmt_pkg::PH_HDR;
        ent_d   = 1'b0;
      end else begin
        unique case (phase_q)
          ts_pmt_pkg::PH_HDR: begin
            case (off_i)
              OFF_W'(0): if (byte_i != ts_pmt_pkg::TS_SYNC) phase_d = ts_pmt_pkg::PH_FAIL;
              OFF_W'(1): if (byte_i[7] || !byte_i[6]) phase_d = ts_pmt_pkg::PH_FAIL;
              OFF_W'(3): begin
                if ((byte_i & ts_pmt_pkg::SCR_MASK) != 8'h0 || !byte_i[4]) begin
                  phase_d = ts_pmt_pkg::PH_FAIL;
                end else if (byte_i[5]) begin
                  phase_d = ts_pmt_pkg::PH_ADAPT;
                end else begin
                  nf_d    = PW'(4);
                  phase_d = ts_pmt_pkg::PH_PTR;
                end
              end
              default: ;
            endcase
          end
          ts_pmt_pkg::PH_ADAPT: begin
            // adaptation length byte plus its contents
            nf_d    = PW'(byte_i) + PW'(5);
            phase_d = (nf_d >= LenP) ? ts_pmt_pkg::PH_FAIL : ts_pmt_pkg::PH_PTR;
          end
          ts_pmt_pkg::PH_PTR: begin
            if (offp == nf_q) begin
              sum = offp + PW'(byte_i) + PW'(1);
              if (sum + PW'(11) >= LenP) begin
                phase_d = ts_pmt_pkg::PH_FAIL;
              end else begin
                dpos_d  = sum[OFF_W-1:0];
                crc_d   = ts_pmt_pkg::CRC_INIT;
                phase_d = ts_pmt_pkg::PH_SEC;
              end
            end
          end
          ts_pmt_pkg::PH_SEC: begin
            if (off_i >= dpos_q) begin
              crc_d = ts_pmt_pkg::crc_feed(crc_q, byte_i);
              case (k)
                OFF_W'(0): if (byte_i != ts_pmt_pkg::PMT_TID) phase_d = ts_pmt_pkg::PH_FAIL;
                OFF_W'(1): begin
                  hi_d = byte_i[3:0];
                  if ((byte_i & ts_pmt_pkg::SYN_MASK) != ts_pmt_pkg::SYN_VAL) begin
                    phase_d = ts_pmt_pkg::PH_FAIL;
                  end
                end
                OFF_W'(2): end_d = PW'(dpos_q) + PW'(3) + PW'({hi_q, byte_i});
                OFF_W'(6), OFF_W'(7): if (byte_i != 8'h0) phase_d = ts_pmt_pkg::PH_FAIL;
                OFF_W'(10): begin
                  hi_d = byte_i[3:0];
                  if ((byte_i & ts_pmt_pkg::PI_RSV) != 8'h0) phase_d = ts_pmt_pkg::PH_FAIL;
                end
                OFF_W'(11): begin
                  nf_d    = PW'(dpos_q) + PW'(12) + PW'({hi_q, byte_i});
                  first_d = 1'b1;
                  fok_d   = 1'b0;
                  ent_d   = 1'b0;
                  phase_d = ts_pmt_pkg::PH_ENTRY;
                end
                default: ;
              endcase
            end
          end
          ts_pmt_pkg::PH_ENTRY: begin
            if (!ent_q) begin
              if (offp == nf_q) begin
                // entry start: keep crc and columns up to here
                snap_d  = crc_q;
                csnap_d = col_q;
                cap_d   = {24'h0, byte_i};
                capn_d  = 3'd1;
                if (!(nf_q + PW'(4) < end_q) || nf_q + PW'(5) >= LenP) begin
                  stop_d  = nf_q[OFF_W-1:0];
                  phase_d = ts_pmt_pkg::PH_TAIL;
                end else begin
                  crc_d  = ts_pmt_pkg::crc_feed(crc_q, byte_i);
                  ent_d  = 1'b1;
                  ecnt_d = 3'd1;
                  for (int c = 0; c < 8; c++) begin
                    col_d[c] = first_q ? ts_pmt_pkg::crc_feed(32'h0, 8'(1 << c))
                                       : ts_pmt_pkg::crc_feed(col_q[c], 8'h0);
                  end
                  if (first_q) begin
                    ftype_d = byte_i;
                    fpos_d  = off_i;
                  end
                end
              end else begin
                crc_d = ts_pmt_pkg::crc_feed(crc_q, byte_i);
                for (int c = 0; c < 8; c++) col_d[c] = ts_pmt_pkg::crc_feed(col_q[c], 8'h0);
              end
            end else begin
              crc_d  = ts_pmt_pkg::crc_feed(crc_q, byte_i);
              ecnt_d = ecnt_q + 3'd1;
              for (int c = 0; c < 8; c++) col_d[c] = ts_pmt_pkg::crc_feed(col_q[c], 8'h0);
              if (capn_q < 3'd4) begin
                cap_d  = {cap_q[23:0], byte_i};
                capn_d = capn_q + 3'd1;
              end
              case (ecnt_q)
                3'd1: begin
                  if ((byte_i & ts_pmt_pkg::PID_RSV) != ts_pmt_pkg::PID_RSV) begin
                    stop_d  = nf_q[OFF_W-1:0];
                    ent_d   = 1'b0;
                    phase_d = ts_pmt_pkg::PH_TAIL;
                  end
                end
                3'd3: begin
                  hi_d = byte_i[3:0];
                  if ((byte_i & ts_pmt_pkg::ES_RSV) != ts_pmt_pkg::ES_RSV) begin
                    stop_d  = nf_q[OFF_W-1:0];
                    ent_d   = 1'b0;
                    phase_d = ts_pmt_pkg::PH_TAIL;
                  end
                end
                3'd4: begin
                  nf_d    = nf_q + PW'(5) + PW'({hi_q, byte_i});
                  ent_d   = 1'b0;
                  first_d = 1'b0;
                  if (first_q) fok_d = 1'b1;
                end
                default: ;
              endcase
            end
          end
          ts_pmt_pkg::PH_TAIL: begin
            // finish capturing the stored crc
            if (capn_q < 3'd4) begin
              cap_d  = {cap_q[23:0], byte_i};
              capn_d = capn_q + 3'd1;
            end
          end
          ts_pmt_pkg::PH_FAIL: ;
          default: phase_d = ts_pmt_pkg::PH_FAIL;
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ts_pmt_pkg::PH_HDR;
      ent_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ent_q   <= ent_d;
    end
  end

  // parse payload registers
  always_ff @(posedge clk_i) begin
    nf_q    <= nf_d;
    end_q   <= end_d;
    dpos_q  <= dpos_d;
    fpos_q  <= fpos_d;
    stop_q  <= stop_d;
    hi_q    <= hi_d;
    first_q <= first_d;
    fok_q   <= fok_d;
    ftype_q <= ftype_d;
    ecnt_q  <= ecnt_d;
    capn_q  <= capn_d;
    crc_q   <= crc_d;
    snap_q  <= snap_d;
    cap_q   <= cap_d;
    col_q   <= col_d;
    csnap_q <= csnap_d;
  end

  // crc change from swapping the type byte, linear in the difference
  assign dif = ftype_q ^ replace_i;
  always_comb begin
    delta = '0;
    for (int c = 0; c < 8; c++) begin
      if (dif[c]) delta = delta ^ csnap_q[c];
    end
  end

  assign patch_ok = (phase_q == ts_pmt_pkg::PH_TAIL) && fok_q && (ftype_q == match_i) &&
                    (PW'(stop_q) + PW'(4) < LenP);

  assign plan_o.patch_off = patch_ok ? 8'(fpos_q) : 8'h0;
  assign plan_o.patch_val = replace_i;
  assign plan_o.crc_off   = 8'(stop_q);
  assign plan_o.crc_val   = snap_q ^ delta;
  assign plan_o.crc_en    = patch_ok && (cap_q == snap_q);

endmodule

// ----- design/ts_pmt_stream_type_patcher.sv -----
`timescale 1ns / 1ps
// channel  | dir | payload                                                  | handshake
// in_i     | in  | in_byte                                                  | valid/ready
// out_o    | out | out_byte, out_valid, out_first, type_patched, crc_rewritten | valid/ready
//
// one byte per cycle in and out while the output is not stalled; each byte leaves one packet after it came in
// packet store is a single memory, read and written at the same offset per transaction
// the pmt patch plan is built while the packet streams in and is ready at its last byte
// reset clears control state only; the packet store needs no clearing pass
// in_i.ready drops only while the output register is full and not taken
module ts_pmt_stream_type_patcher #(
  parameter int unsigned PACKET_LEN = 188
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ts_pmt_in_if.sink           in_i,
  ts_pmt_out_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  localparam int unsigned OFF_W = $clog2(PACKET_LEN);

  logic [7:0]        match_q, replace_q;
  logic [OFF_W-1:0]  off_q;
  logic              primed_q;
  logic              acc, last;
  ts_pmt_pkg::plan_t plan, cur_q;

  logic [7:0]        mem_q [PACKET_LEN];
  logic [7:0]        rdata_q;
  logic              ovld_q, prm_q, frst_q, pat_q, crch_q;
  logic [7:0]        alt_q;

  logic              pat_hit, crc_hit;
  logic [OFF_W-1:0]  rel;
  logic [7:0]        crc_byte;

  assign in_i.ready = !ovld_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign last       = (off_q == OFF_W'(PACKET_LEN - 1));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= ts_pmt_pkg::MATCH_RST;
      replace_q <= ts_pmt_pkg::REPLACE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ts_pmt_pkg::REG_MATCH:   match_q   <= cfg_data_i;
        ts_pmt_pkg::REG_REPLACE: replace_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ts_pmt_parser #(
    .PACKET_LEN (PACKET_LEN),
    .OFF_W      (OFF_W)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .last_i    (last),
    .off_i     (off_q),
    .byte_i    (in_i.in_byte),
    .match_i   (match_q),
    .replace_i (replace_q),
    .plan_o    (plan)
  );

  // offset counter, priming and patch plan of the packet now leaving
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      primed_q <= 1'b0;
      cur_q    <= '0;
    end else if (acc) begin
      off_q <= last ? '0 : off_q + OFF_W'(1);
      if (last) begin
        primed_q <= 1'b1;
        cur_q    <= plan;
      end
    end
  end

  // override decisions for the outgoing byte
  assign rel     = off_q - OFF_W'(cur_q.crc_off);
  assign pat_hit = primed_q && (cur_q.patch_off != 8'h0) && (8'(off_q) == cur_q.patch_off);
  assign crc_hit = primed_q && cur_q.crc_en && (8'(off_q) >= cur_q.crc_off) &&
                   (rel < OFF_W'(4));
  always_comb begin
    case (rel[1:0])
      2'd0:    crc_byte = cur_q.crc_val[31:24];
      2'd1:    crc_byte = cur_q.crc_val[23:16];
      2'd2:    crc_byte = cur_q.crc_val[15:8];
      default: crc_byte = cur_q.crc_val[7:0];
    endcase
  end

  // packet store: read old byte, write new one at the same offset
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rdata_q       <= mem_q[off_q];
      mem_q[off_q]  <= in_i.in_byte;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      prm_q  <= primed_q;
      frst_q <= primed_q && (off_q == '0);
      pat_q  <= pat_hit;
      crch_q <= crc_hit;
      alt_q  <= crc_hit ? crc_byte : cur_q.patch_val;
    end
  end

  // output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (acc) begin
      ovld_q <= 1'b1;
    end else if (out_o.ready) begin
      ovld_q <= 1'b0;
    end
  end

  assign out_o.valid         = ovld_q;
  assign out_o.out_byte      = !prm_q ? 8'h0 : ((pat_q || crch_q) ? alt_q : rdata_q);
  assign out_o.out_valid     = prm_q;
  assign out_o.out_first     = frst_q;
  assign out_o.type_patched  = pat_q;
  assign out_o.crc_rewritten = crch_q;

endmodule

// ----- design/ts_pmt_checker.sv -----
`timescale 1ns / 1ps
`include "ts_pmt_stream_type_patcher_assert.svh"
module ts_pmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       o_valid,
  input logic       o_ready,
  input logic [7:0] o_byte,
  input logic       o_primed,
  input logic       o_first,
  input logic       o_patched,
  input logic       o_crc
);

  // a stalled transaction stays offered
  `TPP_ASSERT_NEXT(a_hold, o_valid && !o_ready, o_valid, "output dropped while stalled")

  // type byte and crc bytes never coincide
  `TPP_ASSERT_NOW(a_excl, o_valid, !(o_patched && o_crc), "patch and crc on one byte")

  // before the first packet everything reads zero
  `TPP_ASSERT_NOW(a_unprimed, o_valid && !o_primed,
                  o_byte == 8'h0 && !o_first && !o_patched && !o_crc,
                  "output before first packet not zero")

  // first-byte marker never carries a patch
  `TPP_ASSERT_NOW(a_first, o_valid && o_first, !o_patched && !o_crc,
                  "patch on first packet byte")

endmodule

bind ts_pmt_stream_type_patcher ts_pmt_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .o_valid   (out_o.valid),
  .o_ready   (out_o.ready),
  .o_byte    (out_o.out_byte),
  .o_primed  (out_o.out_valid),
  .o_first   (out_o.out_first),
  .o_patched (out_o.type_patched),
  .o_crc     (out_o.crc_rewritten)
);
